>>> hdl/dcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCS trigger package
// Register map, register reset values and the configuration bundle shared
// by the register file and the trigger core.
// ----------------------------------------------------------------------------
package dcs_pkg;

	// Fixed widths of the configuration registers.
	localparam int THR_BITS   = 12;
	localparam int START_BITS = 8;
	localparam int TPS_BITS   = 7;

	// Register index, taken from paddr[3:2].
	localparam int REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_START_TICK = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_TICKS_PER  = 2'd2;

	localparam logic [THR_BITS-1:0]   THRESHOLD_RESET  = 12'd45;
	localparam logic [START_BITS-1:0] START_TICK_RESET = 8'd0;
	localparam logic [TPS_BITS-1:0]   TICKS_PER_RESET  = 7'd2;

	// Number of samples kept around the peak.
	localparam int WIN_LEN = 4;

	typedef struct packed {
		logic [THR_BITS-1:0]   threshold;
		logic [START_BITS-1:0] start_tick;
		logic [TPS_BITS-1:0]   ticks_per_sample;
	} cfg_t;

endpackage

>>> hdl/dcs_threshold_peak_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCS threshold peak trigger
// Finds the correlated double-sample peak of an ADC trace and reports its
// tick and the four samples ending at it.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the sample channel (sample_valid / sample_ready), one item
// per ADC sample, with last_sample set on the final sample of a trace. Results
// leave on the result channel (result_valid / result_ready): at most one per
// trace, either the fired peak (found = 1) or, on the last sample of a trace
// with no trigger, an all-zero not-found item.
// An accepted sample lands in an input register; as it moves on, the trigger
// decision runs and loads the result register, which then offers the result.
// The block takes one sample per cycle for as long as the result register is
// empty or being drained.
// When the receiver stalls, a held result keeps the result register full, the
// input register holds the next sample, and sample_ready drops only when both
// are occupied. Samples that produce no result also wait in the input register
// until the held result has been taken.
// Reset clears both registers, loads the configuration reset values and opens
// a fresh trace whose first tick is the start_tick reset value. A start_tick
// write is used from the next trace on; a tick step write from the next sample.
// ----------------------------------------------------------------------------
module dcs_threshold_peak_trigger #(
	parameter int LOOKBACK    = 3,
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Sample channel.
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_sample,
	// Result channel.
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   found,
	output logic [TICK_BITS-1:0]   peak_tick,
	output logic signed [SAMPLE_BITS:0] peak_difference,
	output logic [SAMPLE_BITS-1:0] pre_sample_three,
	output logic [SAMPLE_BITS-1:0] pre_sample_two,
	output logic [SAMPLE_BITS-1:0] pre_sample_one,
	output logic [SAMPLE_BITS-1:0] peak_sample
);

	dcs_pkg::cfg_t cfg;

	// Input register.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;

	// The item in the input register moves on when the result register can
	// take whatever it produces this cycle.
	logic advance;
	logic in_accept;

	// Core result, before the result register.
	logic                     res_valid;
	logic                     res_found;
	logic [TICK_BITS-1:0]     res_tick;
	logic signed [SAMPLE_BITS:0] res_diff;
	logic [SAMPLE_BITS-1:0]   res_pre3;
	logic [SAMPLE_BITS-1:0]   res_pre2;
	logic [SAMPLE_BITS-1:0]   res_pre1;
	logic [SAMPLE_BITS-1:0]   res_peak;

	// Result register.
	logic                     out_valid_q;
	logic                     found_q;
	logic [TICK_BITS-1:0]     tick_q;
	logic signed [SAMPLE_BITS:0] diff_q;
	logic [SAMPLE_BITS-1:0]   pre3_q;
	logic [SAMPLE_BITS-1:0]   pre2_q;
	logic [SAMPLE_BITS-1:0]   pre1_q;
	logic [SAMPLE_BITS-1:0]   peak_q;

	assign pready = 1'b1;

	dcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign advance      = valid_s1 && (!out_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign in_accept    = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
	end

	dcs_core #(
		.LOOKBACK    (LOOKBACK),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TICK_BITS   (TICK_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.step             (advance),
		.sample           (sample_s1),
		.last_sample      (last_s1),
		.res_valid        (res_valid),
		.found            (res_found),
		.peak_tick        (res_tick),
		.peak_difference  (res_diff),
		.pre_sample_three (res_pre3),
		.pre_sample_two   (res_pre2),
		.pre_sample_one   (res_pre1),
		.peak_sample      (res_peak)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			found_q <= res_found;
			tick_q  <= res_tick;
			diff_q  <= res_diff;
			pre3_q  <= res_pre3;
			pre2_q  <= res_pre2;
			pre1_q  <= res_pre1;
			peak_q  <= res_peak;
		end
	end

	assign result_valid     = out_valid_q;
	assign found            = found_q;
	assign peak_tick        = tick_q;
	assign peak_difference  = diff_q;
	assign pre_sample_three = pre3_q;
	assign pre_sample_two   = pre2_q;
	assign pre_sample_one   = pre1_q;
	assign peak_sample      = peak_q;

`ifndef SYNTHESIS
	// A not-found item carries nothing but zeros.
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (peak_tick == '0 && peak_difference == '0 &&
		pre_sample_three == '0 && pre_sample_two == '0 &&
		pre_sample_one == '0 && peak_sample == '0))
		else $error("not-found item has nonzero fields");

	// A fired peak was above a non-negative threshold, so it is positive.
	a_peak_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && found) |-> (peak_difference > 0))
		else $error("fired peak difference is not positive");

	// An accepted sample always occupies the input register next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted sample did not reach the input register");

	// A sample blocked by a full result register is not dropped.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1) && $stable(last_s1)))
		else $error("stalled sample lost from the input register");
`endif

endmodule

>>> hdl/dcs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCS trigger register file
// APB-style configuration registers: threshold, start tick and tick step.
// ----------------------------------------------------------------------------
module dcs_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output dcs_pkg::cfg_t       cfg
);

	dcs_pkg::cfg_t                       cfg_q;
	logic [dcs_pkg::REG_IDX_BITS-1:0]    idx;
	logic                                wr_en;

	assign idx   = paddr[3:2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold        <= dcs_pkg::THRESHOLD_RESET;
			cfg_q.start_tick       <= dcs_pkg::START_TICK_RESET;
			cfg_q.ticks_per_sample <= dcs_pkg::TICKS_PER_RESET;
		end else if (wr_en) begin
			case (idx)
				dcs_pkg::REG_THRESHOLD: begin
					cfg_q.threshold <= pwdata[dcs_pkg::THR_BITS-1:0];
				end
				dcs_pkg::REG_START_TICK: begin
					cfg_q.start_tick <= pwdata[dcs_pkg::START_BITS-1:0];
				end
				dcs_pkg::REG_TICKS_PER: begin
					cfg_q.ticks_per_sample <= pwdata[dcs_pkg::TPS_BITS-1:0];
				end
				default: begin
					// Writes past the register list are dropped.
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			dcs_pkg::REG_THRESHOLD:  prdata = 32'(cfg_q.threshold);
			dcs_pkg::REG_START_TICK: prdata = 32'(cfg_q.start_tick);
			dcs_pkg::REG_TICKS_PER:  prdata = 32'(cfg_q.ticks_per_sample);
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/dcs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCS trigger core
// Per-trace state and the single-pass arm, peak and fire decision.
// ----------------------------------------------------------------------------
module dcs_core #(
	parameter int LOOKBACK    = 3,
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcs_pkg::cfg_t          cfg,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_sample,
	output logic                   res_valid,
	output logic                   found,
	output logic [TICK_BITS-1:0]   peak_tick,
	output logic signed [SAMPLE_BITS:0] peak_difference,
	output logic [SAMPLE_BITS-1:0] pre_sample_three,
	output logic [SAMPLE_BITS-1:0] pre_sample_two,
	output logic [SAMPLE_BITS-1:0] pre_sample_one,
	output logic [SAMPLE_BITS-1:0] peak_sample
);

	localparam int HDEPTH = (LOOKBACK > 3) ? LOOKBACK : 3;
	localparam int FILL_W = $clog2(HDEPTH + 1);
	localparam int CMP_W  =
		((SAMPLE_BITS > dcs_pkg::THR_BITS) ? SAMPLE_BITS : dcs_pkg::THR_BITS) + 2;

	logic [SAMPLE_BITS-1:0]    hist_q [HDEPTH];
	logic [SAMPLE_BITS-1:0]    win_q  [dcs_pkg::WIN_LEN];
	logic [FILL_W-1:0]         fill_q;
	logic [TICK_BITS-1:0]      tick_q;
	logic                      armed_q;
	logic                      fired_q;
	logic signed [SAMPLE_BITS:0] best_q;
	logic [TICK_BITS-1:0]      best_tick_q;

	logic signed [SAMPLE_BITS:0] diff;
	logic signed [CMP_W-1:0]   diff_x;
	logic signed [CMP_W-1:0]   thr_x;
	logic                      active;
	logic                      above;
	logic                      fire;
	logic                      armed_nxt;
	logic                      update;

	assign diff   = $signed({1'b0, sample}) - $signed({1'b0, hist_q[LOOKBACK-1]});
	assign diff_x = CMP_W'(diff);
	assign thr_x  = $signed({{(CMP_W - dcs_pkg::THR_BITS){1'b0}}, cfg.threshold});

	assign active    = !fired_q && (fill_q >= FILL_W'(LOOKBACK));
	assign above     = diff_x > thr_x;
	assign fire      = active && !above && armed_q && (diff < best_q);
	assign armed_nxt = armed_q || (active && above);
	assign update    = active && !fire && armed_nxt && (diff > best_q);

	// A result leaves on a fire, or on the last sample of a trace that never fired.
	assign res_valid        = fire || (last_sample && !fired_q);
	assign found            = fire;
	assign peak_tick        = fire ? best_tick_q : '0;
	assign peak_difference  = fire ? best_q : '0;
	assign pre_sample_three = fire ? win_q[0] : '0;
	assign pre_sample_two   = fire ? win_q[1] : '0;
	assign pre_sample_one   = fire ? win_q[2] : '0;
	assign peak_sample      = fire ? win_q[3] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HDEPTH; i++) hist_q[i] <= '0;
			for (int i = 0; i < dcs_pkg::WIN_LEN; i++) win_q[i] <= '0;
			fill_q      <= '0;
			tick_q      <= TICK_BITS'(dcs_pkg::START_TICK_RESET);
			armed_q     <= 1'b0;
			fired_q     <= 1'b0;
			best_q      <= '0;
			best_tick_q <= '0;
		end else if (step) begin
			if (last_sample) begin
				// The next item opens a fresh trace.
				for (int i = 0; i < HDEPTH; i++) hist_q[i] <= '0;
				for (int i = 0; i < dcs_pkg::WIN_LEN; i++) win_q[i] <= '0;
				fill_q      <= '0;
				tick_q      <= TICK_BITS'(cfg.start_tick);
				armed_q     <= 1'b0;
				fired_q     <= 1'b0;
				best_q      <= '0;
				best_tick_q <= '0;
			end else begin
				hist_q[0] <= sample;
				for (int i = 1; i < HDEPTH; i++) hist_q[i] <= hist_q[i-1];
				if (fill_q < FILL_W'(HDEPTH)) fill_q <= fill_q + FILL_W'(1);
				tick_q  <= tick_q + TICK_BITS'(cfg.ticks_per_sample);
				armed_q <= armed_nxt;
				fired_q <= fired_q | fire;
				if (update) begin
					best_q      <= diff;
					best_tick_q <= tick_q;
					win_q[0]    <= hist_q[2];
					win_q[1]    <= hist_q[1];
					win_q[2]    <= hist_q[0];
					win_q[3]    <= sample;
				end
			end
		end
	end

endmodule

>>> bench/dcs_threshold_peak_trigger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCS threshold peak trigger testbench
// Streams ADC traces into the trigger through the sample channel and checks
// every report on the result channel against a cycle-free model of the
// trigger kept inside the bench. Registers are reprogrammed over the APB port
// between traffic phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module dcs_threshold_peak_trigger_tb;

	// Register index past the end of the map; writes to it must be dropped.
	localparam logic [dcs_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	// Cycles to let pass after the last report before touching the registers
	// or ending the run. A sample passes the input register before it reaches
	// the result register, so the margin also covers samples that report nothing.
	localparam int SETTLE_CYCLES = 6;

	// Cycles without any handshake after which the run is declared hung.
	localparam int HANG_LIMIT = 2000;

	// One report of the trigger, laid out like the result ports.
	typedef struct packed {
		logic               found;
		logic [15:0]        peak_tick;
		logic signed [12:0] peak_difference;
		logic [11:0]        pre_sample_three;
		logic [11:0]        pre_sample_two;
		logic [11:0]        pre_sample_one;
		logic [11:0]        peak_sample;
	} peak_report_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid;
	logic        sample_ready;
	logic [11:0] sample;
	logic        last_sample;
	logic        result_valid;
	logic        result_ready;
	logic        found;
	logic [15:0] peak_tick;
	logic signed [12:0] peak_difference;
	logic [11:0] pre_sample_three;
	logic [11:0] pre_sample_two;
	logic [11:0] pre_sample_one;
	logic [11:0] peak_sample;

	dcs_threshold_peak_trigger DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.sample_valid     (sample_valid),
		.sample_ready     (sample_ready),
		.sample           (sample),
		.last_sample      (last_sample),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.found            (found),
		.peak_tick        (peak_tick),
		.peak_difference  (peak_difference),
		.pre_sample_three (pre_sample_three),
		.pre_sample_two   (pre_sample_two),
		.pre_sample_one   (pre_sample_one),
		.peak_sample      (peak_sample)
	);

	// Reports the trigger still owes us, oldest first.
	peak_report_t pending_reports[$];
	int errors = 0;

	// Percentage of cycles in which each side holds back.
	int sender_idle_pct   = 35;
	int receiver_idle_pct = 80;

	// ------------------------------------------------------------------------
	// Trigger model. The register copies follow every APB write the bench
	// makes; the trace state follows every sample the block accepts.
	// ------------------------------------------------------------------------
	logic [11:0] thr_reg;
	logic [7:0]  start_reg;
	logic [6:0]  step_reg;

	logic [11:0] history[3];   // earlier samples, newest in slot 0
	int          history_fill;
	logic [15:0] tick_now;
	logic        armed;
	logic        fired;
	int          best_diff;
	logic [15:0] best_tick;
	logic [11:0] peak_window[4];

	// Clears the per-trace state; the first tick comes from start_tick as it
	// stands at this moment, which is why a start_tick write only shows up on
	// the trace after the one already opened.
	function automatic void open_trace();
		for (int k = 0; k < 3; k++) history[k] = '0;
		for (int k = 0; k < 4; k++) peak_window[k] = '0;
		history_fill = 0;
		tick_now     = {8'd0, start_reg};
		armed        = 1'b0;
		fired        = 1'b0;
		best_diff    = 0;
		best_tick    = '0;
	endfunction

	// Advances the model by one accepted sample and queues any report it causes.
	function automatic void track_sample(input logic [11:0] s, input logic is_last);
		int           diff;
		logic         fire_now;
		peak_report_t rep;
		fire_now = 1'b0;
		if (!fired && history_fill >= 3) begin
			diff = int'(s) - int'(history[2]);
			if (diff > int'(thr_reg)) begin
				armed = 1'b1;
			end else if (armed && diff < best_diff) begin
				fire_now = 1'b1;
			end
			if (fire_now) begin
				fired = 1'b1;
				rep.found            = 1'b1;
				rep.peak_tick        = best_tick;
				rep.peak_difference  = best_diff[12:0];
				rep.pre_sample_three = peak_window[0];
				rep.pre_sample_two   = peak_window[1];
				rep.pre_sample_one   = peak_window[2];
				rep.peak_sample      = peak_window[3];
				pending_reports = {pending_reports, rep};
			end else if (armed && diff > best_diff) begin
				// New peak: keep its tick and the four samples ending at it.
				best_diff      = diff;
				best_tick      = tick_now;
				peak_window[0] = history[2];
				peak_window[1] = history[1];
				peak_window[2] = history[0];
				peak_window[3] = s;
			end
		end
		history[2] = history[1];
		history[1] = history[0];
		history[0] = s;
		if (history_fill < 3) history_fill++;
		tick_now = tick_now + {9'd0, step_reg};
		if (is_last) begin
			// A trace that never fired still owes one all-zero not-found report.
			if (!fired) begin
				rep = '0;
				pending_reports = {pending_reports, rep};
			end
			open_trace();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Clock, receiver stalls, result checking and hang detection.
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver decides afresh each cycle whether it takes a report.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Every report that leaves the block is matched with the oldest one owed.
	always @(posedge clk) begin : report_check
		peak_report_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report: expected none, actual found=%0d tick=%0d",
					$time, found, peak_tick);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("found", want.found, found);
				check_field("peak_tick", want.peak_tick, peak_tick);
				check_field("peak_difference", want.peak_difference, peak_difference);
				check_field("pre_sample_three", want.pre_sample_three, pre_sample_three);
				check_field("pre_sample_two", want.pre_sample_two, pre_sample_two);
				check_field("pre_sample_one", want.pre_sample_one, pre_sample_one);
				check_field("peak_sample", want.peak_sample, peak_sample);
			end
		end
	end

	// Any handshake on any port counts as progress; a long silence is a hang.
	always @(posedge clk) begin : hang_watch
		int quiet_cycles;
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
				|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared drivers.
	// ------------------------------------------------------------------------

	// Offers one sample, possibly after a random gap, and waits until the block
	// takes it. Valid stays high on return so back-to-back items need no gap.
	task automatic send_sample(input logic [11:0] s, input logic is_last);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		last_sample  <= is_last;
		do @(posedge clk); while (!sample_ready);
		track_sample(s, is_last);
	endtask

	// Sends a whole trace; the final value carries last_sample.
	task automatic send_trace(input int values[$]);
		for (int k = 0; k < values.size(); k++)
			send_sample(values[k][11:0], k == values.size() - 1);
	endtask

	// Stops the sample stream and waits until every owed report is out and the
	// pipeline has had time to empty behind it.
	task automatic drain_reports();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write, followed by a read-back of the same register unless it is unmapped. Only call this
	// while the block is drained.
	task automatic write_register(input logic [dcs_pkg::REG_IDX_BITS-1:0] idx,
			input logic [31:0] value);
		logic [31:0] stored;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			dcs_pkg::REG_THRESHOLD:  thr_reg   = value[dcs_pkg::THR_BITS-1:0];
			dcs_pkg::REG_START_TICK: start_reg = value[dcs_pkg::START_BITS-1:0];
			dcs_pkg::REG_TICKS_PER:  step_reg  = value[dcs_pkg::TPS_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_UNUSED) begin
			psel <= 1'b0;
		end else begin
			// Read back what the register now holds.
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			case (idx)
				dcs_pkg::REG_THRESHOLD:  stored = {20'd0, thr_reg};
				dcs_pkg::REG_START_TICK: stored = {24'd0, start_reg};
				default:                 stored = {25'd0, step_reg};
			endcase
			if (prdata !== stored) begin
				$display("%0t: register %0d read-back mismatch: expected %h, actual %h",
					$time, idx, stored, prdata);
				errors++;
			end
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	function automatic int clamp_adc(input int v);
		return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
	endfunction

	// Sends random traces until about item_goal samples have gone in. Most are
	// well-shaped pulses sized against the current threshold so that they arm,
	// peak and fall; the rest are full-range noise and stubby broken traces.
	task automatic send_random_traces(input int item_goal);
		int sent;
		int kind;
		int base;
		int amp;
		int rise;
		int fall;
		int trace[$];
		sent = 0;
		while (sent < item_goal) begin
			trace = {};
			kind  = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 20)) trace = {trace, int'($urandom_range(0, 4095))};
			end else if (kind == 1) begin
				repeat ($urandom_range(1, 4)) trace = {trace, int'($urandom_range(0, 4095))};
			end else begin
				base = $urandom_range(0, 2500);
				amp  = int'(thr_reg) + $urandom_range(1, 900);
				rise = $urandom_range(1, 5);
				fall = $urandom_range(1, 8);
				repeat ($urandom_range(0, 6))
					trace = {trace, clamp_adc(base + $urandom_range(0, 8))};
				for (int k = 1; k <= rise; k++)
					trace = {trace,
						clamp_adc(base + amp * k / rise + $urandom_range(0, 40) - 20)};
				for (int k = 1; k <= fall; k++)
					trace = {trace,
						clamp_adc(base + amp - amp * k / fall + $urandom_range(0, 40) - 20)};
				repeat ($urandom_range(0, 10))
					trace = {trace, clamp_adc(base + $urandom_range(0, 8))};
			end
			send_trace(trace);
			sent += trace.size();
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Runs on the reset register values (threshold 45, start 0, step 2), so
	// it also proves those values.
	task automatic test_directed_traces();
		int trace[$];
		// Full-scale step fires on the full-scale drop; the samples that follow
		// the trigger, up to the last one, must stay silent.
		trace = {0, 0, 0, 4095, 4095, 4095, 0, 0, 4095};
		send_trace(trace);
		// A one-sample trace can only end with a not-found report.
		trace = {4095};
		send_trace(trace);
		// The trigger fires on the last sample: the fired report and nothing else.
		trace = {100, 100, 100, 200, 100};
		send_trace(trace);
		// Armed and still rising when the trace ends: not found.
		trace = {0, 0, 0, 200, 400};
		send_trace(trace);
		// Just above threshold, then flat: armed but never falls below the peak.
		trace = {0, 0, 0, 46, 46, 46};
		send_trace(trace);
		drain_reports();
	endtask

	// Walks every register through its extremes with traces in between.
	task automatic test_register_extremes();
		int trace[$];
		// Zero threshold, zero step: every tick is the same, and a rise of one
		// count arms the trigger.
		write_register(dcs_pkg::REG_THRESHOLD, 32'd0);
		write_register(dcs_pkg::REG_START_TICK, 32'hABCD_12FF);
		write_register(dcs_pkg::REG_TICKS_PER, 32'd0);
		trace = {10, 10, 10, 11, 10, 10};
		send_trace(trace);
		// Full-scale threshold can never be exceeded.
		drain_reports();
		write_register(dcs_pkg::REG_THRESHOLD, 32'd4095);
		trace = {0, 0, 0, 4095, 0, 4095};
		send_trace(trace);
		drain_reports();
		// The unmapped index must not disturb anything.
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		write_register(dcs_pkg::REG_THRESHOLD, 32'd100);
		write_register(dcs_pkg::REG_TICKS_PER, 32'd127);
		trace = {3, 3, 3};
		send_trace(trace);
		// A long flat trace at the largest step carries the tick past 16 bits
		// before the pulse arrives.
		trace = {};
		repeat (540) trace = {trace, int'(1000 + $urandom_range(0, 30))};
		trace = {trace, 1000, 1000, 1000, 1300, 1600, 1700, 1500, 1200, 1000};
		send_trace(trace);
		drain_reports();
		write_register(dcs_pkg::REG_START_TICK, 32'd0);
		write_register(dcs_pkg::REG_TICKS_PER, 32'd1);
		send_random_traces(30);
		drain_reports();
		write_register(dcs_pkg::REG_TICKS_PER, 32'd64);
		send_random_traces(30);
		drain_reports();
	endtask

	// Three phases of random traffic under different stall patterns, each with
	// its own register setting.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 35;
					receiver_idle_pct = 80;
				end
				1: begin
					sender_idle_pct   = 80;
					receiver_idle_pct = 35;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			drain_reports();
			write_register(dcs_pkg::REG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
				(($urandom_range(0, 1) == 0) ? 32'd0 : 32'd4095) : $urandom_range(0, 600));
			write_register(dcs_pkg::REG_START_TICK, $urandom_range(0, 255));
			write_register(dcs_pkg::REG_TICKS_PER, ($urandom_range(0, 3) == 0) ?
				(($urandom_range(0, 1) == 0) ? 32'd0 : 32'd127) : $urandom_range(1, 64));
			send_random_traces(170);
			// Hold the sender off until the block has handed over everything.
			drain_reports();
			send_random_traces(170);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		sample_valid = 1'b0;
		sample       = '0;
		last_sample  = 1'b0;
		result_ready = 1'b0;
		thr_reg      = dcs_pkg::THRESHOLD_RESET;
		start_reg    = dcs_pkg::START_TICK_RESET;
		step_reg     = dcs_pkg::TICKS_PER_RESET;
		open_trace();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_traces();
		test_register_extremes();
		test_random_traffic();

		drain_reports();
		if (pending_reports.size() != 0) begin
			$display("%0t: %0d reports never arrived", $time, pending_reports.size());
			errors++;
		end
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/dcs_pkg.sv
hdl/dcs_regs.sv
hdl/dcs_core.sv
hdl/dcs_threshold_peak_trigger.sv
bench/dcs_threshold_peak_trigger_tb.sv
